FILE: src/directional_binary_thinning_assert.svh
// assertion macros for the thinning block
`ifndef DIRECTIONAL_BINARY_THINNING_ASSERT_SVH
`define DIRECTIONAL_BINARY_THINNING_ASSERT_SVH
`define DBT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define DBT_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

FILE: src/dbt_pkg.sv
// shared types and constants for the thinning block
`default_nettype none
package dbt_pkg;
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_RUN   = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam logic       REG_ROWS  = 1'b0;
  localparam logic       REG_COLS  = 1'b1;
  localparam logic [1:0] SIDE_N = 2'd0;
  localparam logic [1:0] SIDE_S = 2'd1;
  localparam logic [1:0] SIDE_W = 2'd2;
  localparam logic [1:0] SIDE_E = 2'd3;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] row;
    logic [7:0] col;
    logic       pixel_in;
  } in_t;

  typedef struct packed {
    logic        pixel_out;
    logic [15:0] rounds_done;
    logic [15:0] pixels_deleted;
  } out_t;

  // neighbourhood a b k / d x e / f g h
  typedef struct packed {
    logic a, b, k, d, x, e, f, g, h;
  } nbr_t;

  function automatic logic [2:0] cnt7(input logic [6:0] v);
    return 3'(v[0]) + 3'(v[1]) + 3'(v[2]) + 3'(v[3]) + 3'(v[4]) + 3'(v[5]) + 3'(v[6]);
  endfunction

  function automatic logic deletable(input nbr_t n, input logic [1:0] side);
    logic [2:0] s;
    logic ok;
    ok = 1'b0;
    s = 3'd0;
    case (side)
      SIDE_N: begin
        s = cnt7({n.a, n.k, n.d, n.e, n.f, n.g, n.h});
        ok = n.x && !n.b && n.g && s >= 3'd4 &&
             ((n.e && n.k) || (n.f && n.d) || (n.h && n.e) || (n.d && n.a));
      end
      SIDE_S: begin
        s = cnt7({n.a, n.b, n.k, n.d, n.e, n.f, n.h});
        ok = n.x && !n.g && n.b && s >= 3'd4 &&
             ((n.e && n.h) || (n.f && n.d) || (n.a && n.d) || (n.k && n.e));
      end
      SIDE_W: begin
        s = cnt7({n.a, n.b, n.k, n.e, n.f, n.g, n.h});
        ok = n.x && !n.d && n.e && s >= 3'd3 && !(!n.a && !n.g && !n.h) &&
             !(s == 3'd4 && !n.b && !n.k && !n.g) && !(!n.b && !n.k && !n.g && !n.h) &&
             !(!n.b && !n.k && !n.f && !n.h);
      end
      default: begin
        s = cnt7({n.a, n.b, n.k, n.d, n.f, n.g, n.h});
        ok = n.x && !n.e && n.d && s >= 3'd3 && !(!n.b && !n.a && !n.g && !n.f) &&
             !(s == 3'd4 && !n.b && !n.a && !n.g) && !(!n.k && !n.a && !n.g && !n.f) &&
             !(!n.b && !n.k && !n.f && !n.g);
      end
    endcase
    return ok;
  endfunction
endpackage
`default_nettype wire

FILE: src/directional_binary_thinning.sv
// thinning engine top level with two frame stores and the pass sequencer
// Use: drive in and pulse start while busy is low. Commands: pixel write,
// pixel read and run. Every accepted command gives exactly one result on
// out, marked by done for one cycle; the receiver cannot stall it.
// Write: done in the cycle after acceptance, busy stays low.
// Read: two cycles (store read plus result register), busy for one cycle.
// Run: each pass streams the frame from the current store in raster order,
// one pixel per cycle, writing the other store, so a pass takes
// (rows+1)*(cols+1) scan cycles plus 3 drain cycles; a round is four passes
// and the run ends after the first round that deletes nothing.
// A scan of three row lines (two line buffers plus a 3x3 window) sets the
// rate; the two stores swap roles after every pass, so no copy-back exists.
// Configuration: cfg_valid/cfg_ready, register 0 rows, 1 columns; ready is
// high only when the block is idle and start is low. Reset returns the
// sequencer to idle and the registers to 256; the stores are undefined
// until written.
`default_nettype none
module directional_binary_thinning #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 256
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire dbt_pkg::in_t  in,
  output logic               done,
  output dbt_pkg::out_t      out,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic          cfg_index,
  input  wire logic [8:0]    cfg_data
);
  localparam int RW = $clog2(MAX_ROWS + 2);
  localparam int CW = $clog2(MAX_COLS + 2);
  localparam int RA = $clog2(MAX_ROWS);
  localparam int CA = $clog2(MAX_COLS);
  localparam int DEPTH = 2 ** (RA + CA);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_READ = 4'b0010, S_PASS = 4'b0100, S_END = 4'b1000
  } state_t;

  state_t state;
  logic [8:0] num_rows, num_cols;
  logic [RW-1:0] nr;
  logic [CW-1:0] nc;
  logic [RW-1:0] sr;
  logic [CW-1:0] sc;
  logic [1:0] side;
  logic bank;
  logic [15:0] rnd, del_tot;
  logic round_del;
  logic mem0 [DEPTH];
  logic mem1 [DEPTH];
  logic rd0, rd1;
  logic rd_en, rd_ok_q, rd_ok;
  logic [RA+CA-1:0] rd_addr;
  logic lb0 [MAX_COLS];
  logic lb1 [MAX_COLS];
  logic [2:0] w0, w1, w2;
  logic in_q;
  logic [RW-1:0] pr;
  logic [CW-1:0] pc;
  logic pv;
  logic [RW-1:0] wpr;
  logic [CW-1:0] wpc;
  logic wv;
  logic in_range;
  logic wr_en, wr_bank, wr_bit;
  logic [RA+CA-1:0] wr_addr;
  logic scan_last;
  logic cr, cc_v;
  dbt_pkg::nbr_t nb;
  logic del_now;
  logic [RW-1:0] or_r;
  logic [CW-1:0] oc;
  logic out_ok;
  logic done_next;

  assign nr = (32'(num_rows) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(num_rows);
  assign nc = (32'(num_cols) > MAX_COLS) ? CW'(MAX_COLS) : CW'(num_cols);
  assign busy = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE) && !start;
  assign in_range = (32'(in.row) < MAX_ROWS) && (32'(in.col) < MAX_COLS);

  // scan position sr,sc runs over rows 0..nr and cols 0..nc (one extra of each)
  assign cr = (32'(sr) < 32'(nr)) && (32'(sc) < 32'(nc));
  assign scan_last = (sr == nr) && (32'(sc) == 32'(nc));

  always_comb begin
    rd_en = 1'b0;
    rd_addr = '0;
    if (state == S_IDLE && start && in.cmd == dbt_pkg::CMD_READ && in_range) begin
      rd_en = 1'b1;
      rd_addr = {RA'(in.row), CA'(in.col)};
    end else if (state == S_PASS && cr) begin
      rd_en = 1'b1;
      rd_addr = {RA'(sr), CA'(sc)};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd0 <= mem0[rd_addr];
      rd1 <= mem1[rd_addr];
    end
    if (wr_en && !wr_bank) mem0[wr_addr] <= wr_bit;
    if (wr_en && wr_bank) mem1[wr_addr] <= wr_bit;
  end

  assign rd_ok = bank ? rd1 : rd0;
  assign cc_v = rd_ok_q ? rd_ok : 1'b0;

  // window centre is (wpr-1, wpc-1) relative to the last pixel shifted in
  always_comb begin
    nb.a = w2[2]; nb.b = w2[1]; nb.k = w2[0];
    nb.d = w1[2]; nb.x = w1[1]; nb.e = w1[0];
    nb.f = w0[2]; nb.g = w0[1]; nb.h = w0[0];
  end
  assign or_r = wpr - RW'(1);
  assign oc = wpc - CW'(1);
  assign out_ok = wv && wpr != '0 && wpc != '0;
  assign del_now = dbt_pkg::deletable(nb, side);

  always_comb begin
    wr_en = 1'b0;
    wr_bank = 1'b0;
    wr_bit = 1'b0;
    wr_addr = '0;
    if (state == S_IDLE && start && in.cmd == dbt_pkg::CMD_WRITE && in_range) begin
      wr_en = 1'b1;
      wr_bank = bank;
      wr_bit = in.pixel_in;
      wr_addr = {RA'(in.row), CA'(in.col)};
    end else if ((state == S_PASS || state == S_END) && out_ok) begin
      wr_en = 1'b1;
      wr_bank = !bank;
      wr_bit = nb.x && !del_now;
      wr_addr = {RA'(or_r), CA'(oc)};
    end
  end

  always_ff @(posedge clk) begin
    pv <= (state == S_PASS);
    pr <= sr;
    pc <= sc;
    wv <= pv;
    wpr <= pr;
    wpc <= pc;
    rd_ok_q <= cr;
    if (pv) begin
      // a new row starts with the left border columns clear
      w2 <= {(pc == '0) ? 2'b00 : w2[1:0],
             (32'(pc) < MAX_COLS) ? lb1[CA'(pc)] : 1'b0};
      w1 <= {(pc == '0) ? 2'b00 : w1[1:0],
             (32'(pc) < MAX_COLS) ? lb0[CA'(pc)] : 1'b0};
      w0 <= {(pc == '0) ? 2'b00 : w0[1:0], cc_v};
      if (32'(pc) < MAX_COLS) begin
        lb1[CA'(pc)] <= (pr == '0) ? 1'b0 : lb0[CA'(pc)];
        lb0[CA'(pc)] <= cc_v;
      end
    end
  end

  always_comb begin
    case (state)
      S_IDLE: done_next = start && in.cmd != dbt_pkg::CMD_RUN &&
                          in.cmd != dbt_pkg::CMD_READ;
      S_READ: done_next = 1'b1;
      S_END: done_next = !pv && !wv && side == dbt_pkg::SIDE_E && !round_del;
      default: done_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      num_rows <= 9'd256;
      num_cols <= 9'd256;
      done <= 1'b0;
      bank <= 1'b0;
      rnd <= '0;
      del_tot <= '0;
      side <= dbt_pkg::SIDE_N;
      round_del <= 1'b0;
      sr <= '0;
      sc <= '0;
    end else begin
      done <= done_next;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == dbt_pkg::REG_ROWS) num_rows <= cfg_data;
        else num_cols <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            out <= '0;
            in_q <= in_range;
            case (in.cmd)
              dbt_pkg::CMD_READ: state <= S_READ;
              dbt_pkg::CMD_RUN: begin
                state <= S_PASS;
                rnd <= '0;
                del_tot <= '0;
                side <= dbt_pkg::SIDE_N;
                round_del <= 1'b0;
                sr <= '0;
                sc <= '0;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_READ: begin
          out.pixel_out <= in_q & rd_ok;
          state <= S_IDLE;
        end
        S_PASS: begin
          if (out_ok && nb.x && del_now) begin
            round_del <= 1'b1;
            if (del_tot != 16'hFFFF) del_tot <= del_tot + 16'd1;
          end
          if (32'(sc) == 32'(nc)) begin
            sc <= '0;
            sr <= sr + RW'(1);
          end else begin
            sc <= sc + CW'(1);
          end
          if (scan_last) state <= S_END;
        end
        default: begin
          // drain: wait for pipeline to flush the last window
          if (!pv && !wv) begin
            bank <= !bank;
            sr <= '0;
            sc <= '0;
            if (side == dbt_pkg::SIDE_E) begin
              if (rnd != 16'hFFFF) rnd <= rnd + 16'd1;
              if (round_del) begin
                side <= dbt_pkg::SIDE_N;
                round_del <= 1'b0;
                state <= S_PASS;
              end else begin
                out.pixel_out <= 1'b0;
                out.rounds_done <= (rnd != 16'hFFFF) ? rnd + 16'd1 : rnd;
                out.pixels_deleted <= del_tot;
                state <= S_IDLE;
              end
            end else begin
              side <= side + 2'd1;
              state <= S_PASS;
            end
          end else if (out_ok && nb.x && del_now) begin
            round_del <= 1'b1;
            if (del_tot != 16'hFFFF) del_tot <= del_tot + 16'd1;
          end
        end
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: src/dbt_checker.sv
// port checker for the thinning block and its bind
`default_nettype none
`include "directional_binary_thinning_assert.svh"
module dbt_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done,
  input wire logic cfg_valid,
  input wire logic cfg_ready
);
  `DBT_ASSERT_RST(a_rst_idle, $past(rst) |-> !busy && !done, "busy or done after reset")
  `DBT_ASSERT(a_cfg_idle, cfg_ready |-> !busy, "config taken while busy")
  `DBT_ASSERT(a_cfg_alone, (cfg_valid && cfg_ready) |-> !start, "config beside a command")
  `DBT_ASSERT(a_done_ends, (busy && done) |-> 1'b0, "done while still busy")
endmodule
bind directional_binary_thinning dbt_checker u_dbt_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .cfg_valid(cfg_valid), .cfg_ready(cfg_ready)
);
`default_nettype wire
